>>> hdl/assert_macros.svh
// Assertion helpers for the RTL, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define TCC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition in the next cycle follows from a condition now.
`define TCC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define TCC_ASSERT(lbl, clk, rst, prop, msg)
`define TCC_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

>>> hdl/tcc_pkg.sv
package tcc_pkg;

  localparam int ZW = 35;  // angle, signed Q5.30 radians
  localparam int CW = 34;  // sine and cosine, signed Q30
  localparam int AW = 16;  // output angle, signed Q3.13

  typedef logic signed [ZW-1:0] angle_t;
  typedef logic signed [CW-1:0] trig_t;
  typedef logic signed [AW-1:0] q13_t;

  localparam angle_t HALF_PI  = 35'sd1686629713;
  localparam angle_t PI_Z     = 35'sd3373259426;
  localparam trig_t  INV_GAIN = 34'sh026DD3B6A;
  localparam angle_t LIM_Z    = 35'sd25736;
  localparam q13_t   Q13_LIM  = 16'sd25736;
  localparam angle_t ROUND_Z  = 35'sd65536;

  // atan(2^-i) in Q30, truncated
  function automatic angle_t atan_tab(input logic [4:0] i);
    angle_t r;
    case (i)
      5'd0:  r = 35'sh03243F6A8;
      5'd1:  r = 35'sh01DAC6705;
      5'd2:  r = 35'sh00FADBAFC;
      5'd3:  r = 35'sh007F56EA6;
      5'd4:  r = 35'sh003FEAB76;
      5'd5:  r = 35'sh001FFD55B;
      5'd6:  r = 35'sh000FFFAAA;
      5'd7:  r = 35'sh0007FFF55;
      5'd8:  r = 35'sh0003FFFEA;
      5'd9:  r = 35'sh0001FFFFD;
      5'd10: r = 35'sh0000FFFFF;
      5'd11: r = 35'sh00007FFFF;
      5'd12: r = 35'sh00003FFFF;
      5'd13: r = 35'sh00001FFFF;
      5'd14: r = 35'sh00000FFFF;
      5'd15: r = 35'sh000007FFF;
      5'd16: r = 35'sh000003FFF;
      5'd17: r = 35'sh000001FFF;
      5'd18: r = 35'sh000000FFF;
      5'd19: r = 35'sh0000007FF;
      5'd20: r = 35'sh0000003FF;
      5'd21: r = 35'sh0000001FF;
      5'd22: r = 35'sh0000000FF;
      5'd23: r = 35'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round Q5.30 to Q3.13 and clamp to just beyond pi
  function automatic q13_t to_q13(input angle_t z);
    angle_t q;
    q = (z + ROUND_Z) >>> 17;
    if (q > LIM_Z) begin
      q = LIM_Z;
    end else if (q < -LIM_Z) begin
      q = -LIM_Z;
    end
    return q13_t'(q[AW-1:0]);
  endfunction

endpackage

>>> hdl/tcc_sensor_if.sv
interface tcc_sensor_if #(parameter int W = 16) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] acc_x;
  logic signed [W-1:0] acc_y;
  logic signed [W-1:0] acc_z;
  logic signed [W-1:0] mag_x;
  logic signed [W-1:0] mag_y;
  logic signed [W-1:0] mag_z;

  modport source (output valid, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, input ready);
  modport sink   (input valid, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z, output ready);
endinterface

>>> hdl/tcc_angle_if.sv
interface tcc_angle_if import tcc_pkg::*; ();
  logic valid;
  logic ready;
  q13_t roll_angle;
  q13_t pitch_angle;
  q13_t yaw_angle;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

>>> hdl/tilt_compensated_compass_top.sv
// Channel   Direction  Payload                                   Handshake
// sensor    in         acc_x/y/z, mag_x/y/z, SENSOR_BITS signed  valid/ready
// angles    out        roll/pitch/yaw_angle, 16 bit Q3.13        valid/ready
//
// One item per cycle in steady state, unless the output stalls. In order,
// the pipeline holds the root, the roll and pitch atan2 CORDIC units, their
// sine and cosine CORDIC units, the mixer, the yaw atan2 CORDIC unit and the
// output register.
// All stages advance together; a stalled output register holds every stage.
// Reset (rst, synchronous) clears the valid bits only; the data registers are not reset.
`include "assert_macros.svh"
module tilt_compensated_compass_top import tcc_pkg::*; #(
  parameter int SENSOR_BITS  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input logic          clk,
  input logic          rst,
  tcc_sensor_if.sink   sensor,
  tcc_angle_if.source  angles
);
  localparam int S  = SENSOR_BITS;
  localparam int VW = S + 1;   // width into roll and pitch atan2
  localparam int OW = S + 3;   // width of bx, by and into yaw atan2

  // whole pipeline advances when the output register is free or taken
  logic adv;

  // root stage
  logic                sq_v;
  logic [S-1:0]        sq_root;
  logic [6*S-1:0]      sq_side;
  logic signed [S-1:0] ax, ay, az, mx1, my1, mz1;

  // roll and pitch atan2
  logic                pv_v, rv_v;
  angle_t              pitch_z, roll_z;
  logic [2*S-1:0]      pv_side;
  logic [S-1:0]        rv_side;
  q13_t                pitch_q, roll_q;

  // sine and cosine
  logic                rr_v, rp_v;
  trig_t               sr, cr, sp, cp;
  logic [2*S+AW-1:0]   rr_side;
  logic [S+AW-1:0]     rp_side;

  // compensation and heading
  logic                mx_v;
  logic signed [OW-1:0] bx, by;
  logic [2*AW-1:0]     mx_side;
  logic                yv_v;
  angle_t              yaw_z;
  logic [2*AW-1:0]     yv_side;

  // output register
  logic out_v;
  q13_t roll_o, pitch_o, yaw_o;

  assign adv          = !out_v || angles.ready;
  assign sensor.ready = adv;

  tcc_isqrt #(.S(S), .SIDE_W(6*S)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sensor.valid),
    .a         (sensor.acc_x),
    .b         (sensor.acc_z),
    .side_in   ({sensor.acc_x, sensor.acc_y, sensor.acc_z,
                 sensor.mag_x, sensor.mag_y, sensor.mag_z}),
    .out_valid (sq_v),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  assign ax  = sq_side[6*S-1:5*S];
  assign ay  = sq_side[5*S-1:4*S];
  assign az  = sq_side[4*S-1:3*S];
  assign mx1 = sq_side[3*S-1:2*S];
  assign my1 = sq_side[2*S-1:S];
  assign mz1 = sq_side[S-1:0];

  // pitch = atan2(ay, sqrt(ax^2 + az^2)); carries mag x and y along
  tcc_vector #(.W(VW), .STEPS(CORDIC_STEPS), .SIDE_W(2*S)) u_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sq_v),
    .y         (VW'(ay)),
    .x         ($signed({1'b0, sq_root})),
    .side_in   ({mx1, my1}),
    .out_valid (pv_v),
    .z         (pitch_z),
    .side_out  (pv_side)
  );

  // roll = atan2(-ax, az); carries mag z along
  tcc_vector #(.W(VW), .STEPS(CORDIC_STEPS), .SIDE_W(S)) u_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sq_v),
    .y         (-VW'(ax)),
    .x         (VW'(az)),
    .side_in   (mz1),
    .out_valid (rv_v),
    .z         (roll_z),
    .side_out  (rv_side)
  );

  assign pitch_q = to_q13(pitch_z);
  assign roll_q  = to_q13(roll_z);

  tcc_rotate #(.STEPS(CORDIC_STEPS), .SIDE_W(2*S+AW)) u_rot_roll (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pv_v && rv_v),
    .z         (roll_z),
    .side_in   ({pv_side, roll_q}),
    .out_valid (rr_v),
    .s         (sr),
    .c         (cr),
    .side_out  (rr_side)
  );

  tcc_rotate #(.STEPS(CORDIC_STEPS), .SIDE_W(S+AW)) u_rot_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pv_v && rv_v),
    .z         (pitch_z),
    .side_in   ({rv_side, pitch_q}),
    .out_valid (rp_v),
    .s         (sp),
    .c         (cp),
    .side_out  (rp_side)
  );

  tcc_mix #(.S(S), .SIDE_W(2*AW)) u_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (rr_v && rp_v),
    .mx        (rr_side[2*S+AW-1:S+AW]),
    .my        (rr_side[S+AW-1:AW]),
    .mz        (rp_side[S+AW-1:AW]),
    .sr        (sr),
    .cr        (cr),
    .sp        (sp),
    .cp        (cp),
    .side_in   ({rr_side[AW-1:0], rp_side[AW-1:0]}),
    .out_valid (mx_v),
    .bx        (bx),
    .by        (by),
    .side_out  (mx_side)
  );

  // yaw = atan2(-by, bx)
  tcc_vector #(.W(OW), .STEPS(CORDIC_STEPS), .SIDE_W(2*AW)) u_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (mx_v),
    .y         (-by),
    .x         (bx),
    .side_in   (mx_side),
    .out_valid (yv_v),
    .z         (yaw_z),
    .side_out  (yv_side)
  );

  // output register: load whenever the pipeline advances, bubbles included
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= yv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_o  <= yv_side[2*AW-1:AW];
      pitch_o <= yv_side[AW-1:0];
      yaw_o   <= to_q13(yaw_z);
    end
  end

  assign angles.valid       = out_v;
  assign angles.roll_angle  = roll_o;
  assign angles.pitch_angle = pitch_o;
  assign angles.yaw_angle   = yaw_o;

  `TCC_ASSERT(a_angle_range, clk, rst, angles.valid |-> (angles.roll_angle <= Q13_LIM && angles.roll_angle >= -Q13_LIM && angles.pitch_angle <= Q13_LIM && angles.pitch_angle >= -Q13_LIM && angles.yaw_angle <= Q13_LIM && angles.yaw_angle >= -Q13_LIM), "angle beyond clamp limit")
  `TCC_ASSERT(a_atan_lockstep, clk, rst, pv_v == rv_v, "roll and pitch atan2 units out of step")
  `TCC_ASSERT(a_rot_lockstep, clk, rst, rr_v == rp_v, "sine and cosine units out of step")
  `TCC_ASSERT_NEXT(a_stall_holds, clk, rst, !adv, $stable(yv_v) && $stable(yaw_z), "pipeline moved during stall")
endmodule

>>> hdl/tcc_isqrt.sv
// Pipelined integer square root of a*a + b*b, one result bit per stage.
module tcc_isqrt #(
  parameter int S      = 16,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [S-1:0] a,
  input  logic signed [S-1:0] b,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [S-1:0]        root,
  output logic [SIDE_W-1:0]   side_out
);
  localparam int NW = 2 * S;

  logic [S-1:0]      ma, mb;
  logic [NW-1:0]     sqa, sqb;
  logic              v_sq;
  logic [SIDE_W-1:0] side_sq;
  logic [NW-1:0]     n_r    [0:S];
  logic [NW-1:0]     res_r  [0:S];
  logic [SIDE_W-1:0] side_r [0:S];
  logic [S:0]        v_r;
  logic [NW-1:0]     bitv   [0:S-1];
  logic [NW-1:0]     trial  [0:S-1];
  logic [NW-1:0]     n_next   [1:S];
  logic [NW-1:0]     res_next [1:S];

  assign ma = a[S-1] ? S'(-a) : S'(a);
  assign mb = b[S-1] ? S'(-b) : S'(b);

  always_comb begin
    for (int j = 0; j < S; j++) begin
      bitv[j]  = NW'(1) << (2 * (S - 1 - j));
      trial[j] = res_r[j] + bitv[j];
      if (n_r[j] >= trial[j]) begin
        n_next[j+1]   = n_r[j] - trial[j];
        res_next[j+1] = (res_r[j] >> 1) + bitv[j];
      end else begin
        n_next[j+1]   = n_r[j];
        res_next[j+1] = res_r[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sq <= 1'b0;
      v_r  <= '0;
    end else if (en) begin
      v_sq <= in_valid;
      v_r  <= {v_r[S-1:0], v_sq};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqa       <= NW'(ma) * NW'(ma);
      sqb       <= NW'(mb) * NW'(mb);
      side_sq   <= side_in;
      n_r[0]    <= sqa + sqb;
      res_r[0]  <= '0;
      side_r[0] <= side_sq;
      for (int j = 1; j <= S; j++) begin
        n_r[j]    <= n_next[j];
        res_r[j]  <= res_next[j];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = v_r[S];
  assign root      = res_r[S][S-1:0];
  assign side_out  = side_r[S];
endmodule

>>> hdl/tcc_vector.sv
// Vectoring CORDIC: atan2(y, x), one iteration per stage.
module tcc_vector import tcc_pkg::*; #(
  parameter int W      = 17,
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] y,
  input  logic signed [W-1:0] x,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output angle_t              z,
  output logic [SIDE_W-1:0]   side_out
);
  localparam int IW = W + 3;

  logic signed [IW-1:0] xe, ye, fx, fy;
  angle_t               fz;
  logic                 zero_in;
  logic signed [IW-1:0] x_r [0:STEPS];
  logic signed [IW-1:0] y_r [0:STEPS];
  angle_t               z_r [0:STEPS];
  logic                 zero_r [0:STEPS];
  logic [SIDE_W-1:0]    side_r [0:STEPS];
  logic [STEPS:0]       v_r;
  logic signed [IW-1:0] x_next [1:STEPS];
  logic signed [IW-1:0] y_next [1:STEPS];
  angle_t               z_next [1:STEPS];

  // fold the left half plane by a quarter turn
  always_comb begin
    xe      = IW'(x);
    ye      = IW'(y);
    zero_in = (x == '0) && (y == '0);
    if (xe < 0) begin
      if (ye >= 0) begin
        fx = ye;
        fy = -xe;
        fz = HALF_PI;
      end else begin
        fx = -ye;
        fy = xe;
        fz = -HALF_PI;
      end
    end else begin
      fx = xe;
      fy = ye;
      fz = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      if (y_r[i] >= 0) begin
        x_next[i+1] = x_r[i] + (y_r[i] >>> i);
        y_next[i+1] = y_r[i] - (x_r[i] >>> i);
        z_next[i+1] = z_r[i] + atan_tab(5'(i));
      end else begin
        x_next[i+1] = x_r[i] - (y_r[i] >>> i);
        y_next[i+1] = y_r[i] + (x_r[i] >>> i);
        z_next[i+1] = z_r[i] - atan_tab(5'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= fx;
      y_r[0]    <= fy;
      z_r[0]    <= fz;
      zero_r[0] <= zero_in;
      side_r[0] <= side_in;
      for (int i = 1; i <= STEPS; i++) begin
        x_r[i]    <= x_next[i];
        y_r[i]    <= y_next[i];
        z_r[i]    <= z_next[i];
        zero_r[i] <= zero_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // both operands zero give a zero angle
  assign z         = zero_r[STEPS] ? '0 : z_r[STEPS];
  assign out_valid = v_r[STEPS];
  assign side_out  = side_r[STEPS];
endmodule

>>> hdl/tcc_rotate.sv
// Rotation CORDIC: sine and cosine of an angle, one iteration per stage.
module tcc_rotate import tcc_pkg::*; #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  angle_t            z,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output trig_t             s,
  output trig_t             c,
  output logic [SIDE_W-1:0] side_out
);
  angle_t            fz;
  logic              fneg;
  trig_t             x_r [0:STEPS];
  trig_t             y_r [0:STEPS];
  angle_t            z_r [0:STEPS];
  logic              neg_r [0:STEPS];
  logic [SIDE_W-1:0] side_r [0:STEPS];
  logic [STEPS:0]    v_r;
  trig_t             x_next [1:STEPS];
  trig_t             y_next [1:STEPS];
  angle_t            z_next [1:STEPS];

  // move an angle beyond a quarter turn by pi and negate at the end
  always_comb begin
    if (z > HALF_PI) begin
      fz   = z - PI_Z;
      fneg = 1'b1;
    end else if (z < -HALF_PI) begin
      fz   = z + PI_Z;
      fneg = 1'b1;
    end else begin
      fz   = z;
      fneg = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < STEPS; i++) begin
      if (z_r[i] >= 0) begin
        x_next[i+1] = x_r[i] - (y_r[i] >>> i);
        y_next[i+1] = y_r[i] + (x_r[i] >>> i);
        z_next[i+1] = z_r[i] - atan_tab(5'(i));
      end else begin
        x_next[i+1] = x_r[i] + (y_r[i] >>> i);
        y_next[i+1] = y_r[i] - (x_r[i] >>> i);
        z_next[i+1] = z_r[i] + atan_tab(5'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEPS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= INV_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= fz;
      neg_r[0]  <= fneg;
      side_r[0] <= side_in;
      for (int i = 1; i <= STEPS; i++) begin
        x_r[i]    <= x_next[i];
        y_r[i]    <= y_next[i];
        z_r[i]    <= z_next[i];
        neg_r[i]  <= neg_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign c         = neg_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
  assign s         = neg_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
  assign out_valid = v_r[STEPS];
  assign side_out  = side_r[STEPS];
endmodule

>>> hdl/tcc_mix.sv
// Tilt compensation of the magnetometer: bx and by over four stages.
module tcc_mix import tcc_pkg::*; #(
  parameter int S      = 16,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [S-1:0]   mx,
  input  logic signed [S-1:0]   my,
  input  logic signed [S-1:0]   mz,
  input  trig_t                 sr,
  input  trig_t                 cr,
  input  trig_t                 sp,
  input  trig_t                 cp,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic signed [S+2:0]   bx,
  output logic signed [S+2:0]   by,
  output logic [SIDE_W-1:0]     side_out
);
  localparam int OW  = S + 3;
  localparam int PW  = S + CW;
  localparam int EW  = PW + 1;
  localparam int TW  = S + 5;
  localparam int P2W = TW + CW;

  logic signed [PW-1:0]  p1, p2, p3, p4, p5;
  logic signed [EW-1:0]  sum_t, sum_b;
  logic signed [TW-1:0]  t2;
  logic signed [OW-1:0]  q2, by2, q3, by3, bx4, by4;
  trig_t                 sp1, sp2;
  logic signed [P2W-1:0] p6;
  logic [SIDE_W-1:0]     side1, side2, side3, side4;
  logic [3:0]            v_r;

  assign sum_t = EW'(p1) + EW'(p2);
  assign sum_b = EW'(p3) - EW'(p4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products of samples with sine and cosine
      p1    <= PW'(my) * PW'(sr);
      p2    <= PW'(mz) * PW'(cr);
      p3    <= PW'(my) * PW'(cr);
      p4    <= PW'(mz) * PW'(sr);
      p5    <= PW'(mx) * PW'(cp);
      sp1   <= sp;
      side1 <= side_in;
      // scale back to sample units
      t2    <= TW'(sum_t >>> 30);
      by2   <= OW'(sum_b >>> 30);
      q2    <= OW'(p5 >>> 30);
      sp2   <= sp1;
      side2 <= side1;
      // second product on the rolled term
      p6    <= P2W'(t2) * P2W'(sp2);
      q3    <= q2;
      by3   <= by2;
      side3 <= side2;
      // sum up
      bx4   <= q3 + OW'(p6 >>> 30);
      by4   <= by3;
      side4 <= side3;
    end
  end

  assign out_valid = v_r[3];
  assign bx        = bx4;
  assign by        = by4;
  assign side_out  = side4;
endmodule

>>> verif/tb.sv
module tb;
  import tcc_pkg::*;

  // LATENCY is the pipeline depth of the block with the default sizes; the
  // bench settles for a bit longer than that after the last result.
  localparam int LATENCY  = 16 + 3*16 + 10;
  localparam int N_RANDOM = 800;
  localparam int WATCHDOG = 20 * LATENCY + 400;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, mx, my, mz;
  } sample_t;

  typedef struct packed {
    q13_t roll, pitch, yaw;
  } euler_t;

  // One row of the directed table. Where check_fixed is set, the expected
  // angles are typed in and also compared with the predictor.
  typedef struct {
    sample_t   s;
    bit        check_fixed;
    euler_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcc_sensor_if #(.W(16)) sensor ();
  tcc_angle_if            angles ();

  tilt_compensated_compass_top #(.SENSOR_BITS(16), .CORDIC_STEPS(16)) DUT (
    .clk    (clk),
    .rst    (rst),
    .sensor (sensor.sink),
    .angles (angles.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  euler_t    pending_angles[$];
  int        n_errors   = 0;
  int        n_received = 0;
  int        idle_count = 0;
  bit        sending_done = 1'b0;

  // Arithmetic in 64 bits throughout: Q5.30 angles, Q30 sine and cosine.
  function automatic longint atan_step(int i);
    longint t[16] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
    return t[i];
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned acc, bitv;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= acc + bitv) begin
        n   -= acc + bitv;
        acc  = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(acc);
  endfunction

  // Vectoring CORDIC: fold a negative x by a quarter turn, then drive y to zero.
  function automatic longint angle_of(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;  y = -t; z = 64'sd1686629713;
      end else begin
        x = -y; y = t;  z = -64'sd1686629713;
      end
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  // Rotation CORDIC; angles beyond a quarter turn are moved by pi and negated.
  function automatic void sin_cos(longint z, output longint s, output longint c);
    longint x, y, dx, dy;
    bit     flip;
    x = 64'h26DD3B6A;
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic q13_t round_clamp(longint z);
    longint q;
    q = (z + 64'sd65536) >>> 17;
    if (q > 25736) q = 25736;
    if (q < -25736) q = -25736;
    return q13_t'(q);
  endfunction

  function automatic euler_t predict_attitude(sample_t s);
    longint ax, ay, az, mx, my, mz, r, roll, pitch, sr, cr, sp, cp, t, bx, by;
    euler_t a;
    ax = s.ax; ay = s.ay; az = s.az;
    mx = s.mx; my = s.my; mz = s.mz;
    r     = int_sqrt(longint'(ax*ax + az*az));
    pitch = angle_of(ay, r);
    roll  = angle_of(-ax, az);
    sin_cos(roll, sr, cr);
    sin_cos(pitch, sp, cp);
    t  = (my*sr + mz*cr) >>> 30;
    bx = ((mx*cp) >>> 30) + ((t*sp) >>> 30);
    by = (my*cr - mz*sr) >>> 30;
    a.roll  = round_clamp(roll);
    a.pitch = round_clamp(pitch);
    a.yaw   = round_clamp(angle_of(-by, bx));
    return a;
  endfunction

  function automatic void compare_angles(euler_t want, euler_t got, string tag);
    if (got.roll !== want.roll) begin
      $error("%s roll_angle: expected %0d, got %0d", tag, want.roll, got.roll);
      n_errors++;
    end
    if (got.pitch !== want.pitch) begin
      $error("%s pitch_angle: expected %0d, got %0d", tag, want.pitch, got.pitch);
      n_errors++;
    end
    if (got.yaw !== want.yaw) begin
      $error("%s yaw_angle: expected %0d, got %0d", tag, want.yaw, got.yaw);
      n_errors++;
    end
  endfunction

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'(signed'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.ax = rand_axis(); s.ay = rand_axis(); s.az = rand_axis();
    s.mx = rand_axis(); s.my = rand_axis(); s.mz = rand_axis();
    return s;
  endfunction

  // Offer one item after a random gap, hold it until it is taken.
  // Drop valid only when a gap follows, so back to back items keep it high.
  task automatic send_sample(sample_t s);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      sensor.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sensor.valid <= 1'b1;
    sensor.acc_x <= s.ax; sensor.acc_y <= s.ay; sensor.acc_z <= s.az;
    sensor.mag_x <= s.mx; sensor.mag_y <= s.my; sensor.mag_z <= s.mz;
    pending_angles.push_back(predict_attitude(s));
    do @(posedge clk); while (!sensor.ready);
  endtask

  // Directed table: both-zero atan2 cases, axis extremes, rows at pi and at a quarter turn.
  row_t directed[$];

  task automatic add_row(sample_t s, bit fixed = 1'b0, euler_t want = '0);
    row_t r;
    r.s = s; r.check_fixed = fixed; r.want = want;
    directed.push_back(r);
  endtask

  initial begin
    sample_t s;
    euler_t p;
    sensor.valid = 1'b0;
    sensor.acc_x = '0; sensor.acc_y = '0; sensor.acc_z = '0;
    sensor.mag_x = '0; sensor.mag_y = '0; sensor.mag_z = '0;

    // All zero: every atan2 sees two zero operands, so every angle is zero.
    add_row('0, 1'b1, '0);
    // Zero accelerometer with a field: roll and pitch zero, yaw is free.
    add_row('{0, 0, 0, 16'sd1000, 0, 0});
    add_row('{0, 0, 16'sd16384, 16'sd12000, 16'sd3000, -16'sd5000});
    add_row('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    add_row('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    add_row('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    add_row('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
    add_row('{0, 0, -16'sd16384, 0, -16'sd9000, 0});      // upside down, near pi
    add_row('{0, 0, -16'sd1, 16'sd1, 0, 0});
    add_row('{16'sd1, 0, -16'sd16384, -16'sd300, 16'sd300, 16'sd50});
    add_row('{-16'sd1, 0, -16'sd16384, -16'sd300, -16'sd300, 16'sd50});
    add_row('{0, 16'sd16384, 0, 0, 16'sd500, 16'sd500}); // pitch a quarter turn
    add_row('{0, -16'sd16384, 0, 16'sd500, 0, -16'sd500});
    add_row('{16'sd16384, 0, 0, 16'sd200, 16'sd100, 0});
    add_row('{-16'sd16384, 0, 0, -16'sd200, -16'sd100, 16'sd77});
    add_row('{16'sd5000, -16'sd7000, 16'sd9000, -16'sd20000, 16'sd15000, -16'sd8000});
    add_row('{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) begin
      if (directed[k].check_fixed) begin
        p = predict_attitude(directed[k].s);
        compare_angles(directed[k].want, p, "table");
      end
      send_sample(directed[k].s);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      s = rand_sample();
      send_sample(s);
    end
    sensor.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver: random stall per item, with runs of no stall at all.
  int stall_left = 0;
  initial angles.ready = 1'b0;

  always @(posedge clk) begin
    euler_t got;
    int     wait_cycles;
    if (rst) begin
      angles.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 9);
    end else begin
      if (angles.valid && angles.ready) begin
        got.roll  = angles.roll_angle;
        got.pitch = angles.pitch_angle;
        got.yaw   = angles.yaw_angle;
        n_received++;
        if (pending_angles.size() == 0) begin
          $error("result with no expectation waiting");
          n_errors++;
        end else begin
          compare_angles(pending_angles.pop_front(), got, "result");
        end
        wait_cycles = $urandom_range(0, 9);
        if ($urandom_range(0, 2) == 0) wait_cycles = 0;
        stall_left   <= wait_cycles;
        angles.ready <= (wait_cycles == 0);
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        angles.ready <= (stall_left == 1);
      end else begin
        angles.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if (rst || (sensor.valid && sensor.ready) || (angles.valid && angles.ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG) begin
      $display("Watchdog expired with %0d results outstanding", pending_angles.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d sensor items (table rows and random), %0d angle results",
             directed.size() + N_RANDOM, n_received);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hdl
hdl/tcc_pkg.sv
hdl/tcc_sensor_if.sv
hdl/tcc_angle_if.sv
hdl/tcc_isqrt.sv
hdl/tcc_vector.sv
hdl/tcc_rotate.sv
hdl/tcc_mix.sv
hdl/tilt_compensated_compass_top.sv
verif/tb.sv
